FILE: rtl/sobc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo one-pole and biquad chain: shared definitions
// Widths, register indexes, microcode word layout, control store and the
// saturating narrowing function used by the filter datapath.
// ----------------------------------------------------------------------------
package sobc_pkg;

   localparam int SMP_W   = 16;
   localparam int COEF_W  = 17;
   localparam int PROD_W  = COEF_W + SMP_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int CSR_W   = COEF_W;
   localparam int IDX_W   = 3;
   localparam int STEP_W  = 4;

   localparam int POLE_SHIFT = 15;
   localparam int BQ_SHIFT   = 14;

   localparam logic signed [COEF_W-1:0] POLE_GAIN_UNITY = COEF_W'(1 << 15);
   localparam logic signed [SMP_W-1:0]  BQ_B0_UNITY     = SMP_W'(1 << 14);

   localparam logic signed [SMP_W-1:0] SMP_MIN = SMP_W'(-32768);
   localparam logic signed [SMP_W-1:0] SMP_MAX = SMP_W'(32767);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);

   typedef enum logic [IDX_W-1:0] {
      CSR_ENABLE   = 3'd0,
      CSR_POLE_GAIN = 3'd1,
      CSR_POLE_FB  = 3'd2,
      CSR_BQ_B0    = 3'd3,
      CSR_BQ_B1    = 3'd4,
      CSR_BQ_B2    = 3'd5,
      CSR_BQ_A1    = 3'd6,
      CSR_BQ_A2    = 3'd7
   } csr_index_type;

   // Operand pair fed to the shared multiplier.
   typedef enum logic [2:0] {
      MUL_NONE = 3'd0,
      MUL_GAIN = 3'd1,
      MUL_FB   = 3'd2,
      MUL_B0   = 3'd3,
      MUL_B1   = 3'd4,
      MUL_B2   = 3'd5,
      MUL_A1   = 3'd6,
      MUL_A2   = 3'd7
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      WB_NONE = 2'd0,
      WB_POLE = 2'd1,
      WB_BQ   = 2'd2
   } wb_type;

   typedef enum logic [1:0] {
      JMP_NEXT     = 2'd0,
      JMP_POLE_OFF = 2'd1,
      JMP_BQ_OFF   = 2'd2,
      JMP_END      = 2'd3
   } jump_type;

   typedef struct packed {
      mul_sel_type      mul_sel;
      acc_op_type       acc_op;
      wb_type           wb;
      jump_type         jump;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_BQ  = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_END = STEP_W'(11);

   // Control store. The multiplier result is registered, so each product is
   // accumulated in the step after the one that forms it.
   function automatic ucode_type sobc_ucode(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, wb: WB_NONE,
             jump: JMP_NEXT, target: '0};
      unique case (step)
         4'd0:  uc = '{MUL_GAIN, ACC_HOLD, WB_NONE, JMP_POLE_OFF, STEP_BQ};
         4'd1:  uc = '{MUL_FB,   ACC_LOAD, WB_NONE, JMP_NEXT,     '0};
         4'd2:  uc = '{MUL_NONE, ACC_ADD,  WB_NONE, JMP_NEXT,     '0};
         4'd3:  uc = '{MUL_NONE, ACC_HOLD, WB_POLE, JMP_NEXT,     '0};
         4'd4:  uc = '{MUL_B0,   ACC_HOLD, WB_NONE, JMP_BQ_OFF,   STEP_END};
         4'd5:  uc = '{MUL_B1,   ACC_LOAD, WB_NONE, JMP_NEXT,     '0};
         4'd6:  uc = '{MUL_B2,   ACC_ADD,  WB_NONE, JMP_NEXT,     '0};
         4'd7:  uc = '{MUL_A1,   ACC_ADD,  WB_NONE, JMP_NEXT,     '0};
         4'd8:  uc = '{MUL_A2,   ACC_ADD,  WB_NONE, JMP_NEXT,     '0};
         4'd9:  uc = '{MUL_NONE, ACC_ADD,  WB_NONE, JMP_NEXT,     '0};
         4'd10: uc = '{MUL_NONE, ACC_HOLD, WB_BQ,   JMP_NEXT,     '0};
         4'd11: uc = '{MUL_NONE, ACC_HOLD, WB_NONE, JMP_END,      '0};
         default: uc = '{MUL_NONE, ACC_HOLD, WB_NONE, JMP_END,    '0};
      endcase
      return uc;
   endfunction

   function automatic logic signed [SMP_W-1:0] sobc_sat(input logic signed [ACC_W-1:0] v);
      logic signed [SMP_W-1:0] r;
      priority if (v < ACC_MIN) begin
         r = SMP_MIN;
      end else if (v > ACC_MAX) begin
         r = SMP_MAX;
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sobc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo one-pole and biquad chain: sample channels
// Valid/ready channels for the incoming and the filtered stereo samples.
// ----------------------------------------------------------------------------
interface sobc_req_if
   import sobc_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] in_left;
   logic signed [SMP_W-1:0] in_right;

   modport source (output valid, output in_left, output in_right, input ready);
   modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface sobc_rsp_if
   import sobc_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] out_left;
   logic signed [SMP_W-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface
`default_nettype wire

FILE: rtl/stereo_onepole_biquad_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo one-pole and biquad chain
// Per channel, an optional Q15 one-pole filter followed by an optional Q14
// direct-form-1 biquad, run by a microcoded sequencer over one multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  req_chan  in         valid/ready        in_left, in_right
//  rsp_chan  out        valid/ready        out_left, out_right
//  csr_*     in         csr_we, no wait    csr_index, csr_wdata
//
//  The block takes one transaction at a time; the twelve-step program runs
//  once for each channel through the single shared multiplier, skipping the
//  steps of a stage that is off.
//  Reset is synchronous and restores the registers and the filter history.
//  A new transaction is taken once the program has finished, even while a
//  result still waits in the output register; the program stalls on its last
//  step only while that register is full.
// ----------------------------------------------------------------------------
module stereo_onepole_biquad_chain
   import sobc_pkg::*;
   (
      input  wire              clock,
      input  wire              reset,
      sobc_req_if.sink         req_chan,
      sobc_rsp_if.source       rsp_chan,
      input  wire              csr_we,
      input  wire [IDX_W-1:0]  csr_index,
      input  wire [CSR_W-1:0]  csr_wdata
   );

   // Configuration registers.
   logic [1:0]               enable_ff;
   logic signed [COEF_W-1:0] gain_ff;
   logic signed [SMP_W-1:0]  fb_ff, b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   // Filter history, one entry per channel.
   logic signed [SMP_W-1:0] prev_ff [2];
   logic signed [SMP_W-1:0] in1_ff  [2];
   logic signed [SMP_W-1:0] in2_ff  [2];
   logic signed [SMP_W-1:0] out1_ff [2];
   logic signed [SMP_W-1:0] out2_ff [2];

   // Sequencer.
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              chan_ff, chan_in;
   ucode_type         uc;

   // Datapath.
   logic signed [SMP_W-1:0]  x_ff, right_ff, left_res_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic signed [COEF_W-1:0] mul_a;
   logic signed [SMP_W-1:0]  mul_b;
   logic signed [SMP_W-1:0]  pole_res, bq_res;

   // Output register.
   logic                    rsp_valid_ff;
   logic signed [SMP_W-1:0] rsp_left_ff, rsp_right_ff;

   logic req_fire, out_free, chan_switch, finish, pole_wb, bq_wb;
   logic pole_clear, bq_clear;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign uc       = sobc_ucode(step_ff);

   assign req_chan.ready     = !busy_ff;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_left  = rsp_left_ff;
   assign rsp_chan.out_right = rsp_right_ff;

   // An enable write with a bit clear returns that stage to passthrough.
   assign pole_clear = csr_we && (csr_index == CSR_ENABLE) && !csr_wdata[0];
   assign bq_clear   = csr_we && (csr_index == CSR_ENABLE) && !csr_wdata[1];

   always_comb begin
      step_in     = step_ff;
      chan_in     = chan_ff;
      busy_in     = busy_ff;
      chan_switch = 1'b0;
      finish      = 1'b0;
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = '0;
         chan_in = 1'b0;
      end else if (busy_ff) begin
         unique case (uc.jump)
            JMP_NEXT:     step_in = step_ff + STEP_W'(1);
            JMP_POLE_OFF: step_in = enable_ff[0] ? step_ff + STEP_W'(1) : uc.target;
            JMP_BQ_OFF:   step_in = enable_ff[1] ? step_ff + STEP_W'(1) : uc.target;
            JMP_END: begin
               if (!chan_ff) begin
                  chan_switch = 1'b1;
                  chan_in     = 1'b1;
                  step_in     = '0;
               end else if (out_free) begin
                  finish  = 1'b1;
                  busy_in = 1'b0;
                  chan_in = 1'b0;
                  step_in = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (uc.mul_sel)
         MUL_NONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         MUL_GAIN: begin
            mul_a = gain_ff;
            mul_b = x_ff;
         end
         MUL_FB: begin
            mul_a = COEF_W'(fb_ff);
            mul_b = prev_ff[chan_ff];
         end
         MUL_B0: begin
            mul_a = COEF_W'(b0_ff);
            mul_b = x_ff;
         end
         MUL_B1: begin
            mul_a = COEF_W'(b1_ff);
            mul_b = in1_ff[chan_ff];
         end
         MUL_B2: begin
            mul_a = COEF_W'(b2_ff);
            mul_b = in2_ff[chan_ff];
         end
         MUL_A1: begin
            mul_a = COEF_W'(a1_ff);
            mul_b = out1_ff[chan_ff];
         end
         MUL_A2: begin
            mul_a = COEF_W'(a2_ff);
            mul_b = out2_ff[chan_ff];
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      unique case (uc.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   assign pole_res = sobc_sat(acc_ff >>> POLE_SHIFT);
   assign bq_res   = sobc_sat(acc_ff >>> BQ_SHIFT);
   assign pole_wb  = busy_ff && (uc.wb == WB_POLE);
   assign bq_wb    = busy_ff && (uc.wb == WB_BQ);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         chan_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (req_fire) begin
         x_ff     <= req_chan.in_left;
         right_ff <= req_chan.in_right;
      end else if (chan_switch) begin
         x_ff        <= right_ff;
         left_res_ff <= x_ff;
      end else if (pole_wb) begin
         x_ff <= pole_res;
      end else if (bq_wb) begin
         x_ff <= bq_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_left_ff  <= left_res_ff;
         rsp_right_ff <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (csr_we && (csr_index == CSR_ENABLE)) begin
         enable_ff <= csr_wdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || pole_clear) begin
         gain_ff <= POLE_GAIN_UNITY;
         fb_ff   <= '0;
         prev_ff <= '{default: '0};
      end else begin
         if (csr_we && (csr_index == CSR_POLE_GAIN)) gain_ff <= csr_wdata;
         if (csr_we && (csr_index == CSR_POLE_FB))   fb_ff   <= csr_wdata[SMP_W-1:0];
         if (pole_wb) prev_ff[chan_ff] <= pole_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || bq_clear) begin
         b0_ff   <= BQ_B0_UNITY;
         b1_ff   <= '0;
         b2_ff   <= '0;
         a1_ff   <= '0;
         a2_ff   <= '0;
         in1_ff  <= '{default: '0};
         in2_ff  <= '{default: '0};
         out1_ff <= '{default: '0};
         out2_ff <= '{default: '0};
      end else begin
         if (csr_we && (csr_index == CSR_BQ_B0)) b0_ff <= csr_wdata[SMP_W-1:0];
         if (csr_we && (csr_index == CSR_BQ_B1)) b1_ff <= csr_wdata[SMP_W-1:0];
         if (csr_we && (csr_index == CSR_BQ_B2)) b2_ff <= csr_wdata[SMP_W-1:0];
         if (csr_we && (csr_index == CSR_BQ_A1)) a1_ff <= csr_wdata[SMP_W-1:0];
         if (csr_we && (csr_index == CSR_BQ_A2)) a2_ff <= csr_wdata[SMP_W-1:0];
         if (bq_wb) begin
            in2_ff[chan_ff]  <= in1_ff[chan_ff];
            in1_ff[chan_ff]  <= x_ff;
            out2_ff[chan_ff] <= out1_ff[chan_ff];
            out1_ff[chan_ff] <= bq_res;
         end
      end
   end

   // An accepted transaction starts the program on the left channel.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff && (step_ff == '0) && !chan_ff)
      else $error("sequencer did not start on an accepted transaction");

   // The step counter never leaves the program.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_END))
      else $error("step counter outside the control store");

   // While idle the sequencer rests at the first step of the left channel.
   a_idle_rest: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == '0) && !chan_ff)
      else $error("idle sequencer not at its start point");

   // A finished program always leaves a result in the output register.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && !busy_ff)
      else $error("finished program did not present a result");

   // Clearing the one-pole enable restores passthrough.
   a_pole_clear: assert property (@(posedge clock) disable iff (reset)
      pole_clear |=> (gain_ff == POLE_GAIN_UNITY) && (fb_ff == '0)
                     && (prev_ff[0] == '0) && (prev_ff[1] == '0))
      else $error("one-pole stage not restored to passthrough");

endmodule
`default_nettype wire

FILE: tb/tb_stereo_onepole_biquad_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the stereo one-pole and biquad filter chain
// Drives stereo samples under random source gaps and sink stalls, steps a
// scoreboard copy of both filter stages per channel, and compares every
// filtered sample with the prediction. Coefficients and stage enables change
// between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_stereo_onepole_biquad_chain
   import sobc_pkg::*;
   ();

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int HOLD_AT       = 500;
   localparam int HOLD_CYCLES   = 600;

   typedef struct {
      logic signed [SMP_W-1:0] left;
      logic signed [SMP_W-1:0] right;
   } stereo_type;

   // Scoreboard: a cycle-free copy of both stages and the queue of filtered
   // samples that are still owed by the block.
   class filter_scoreboard;
      logic [1:0]               stage_en;
      logic signed [COEF_W-1:0] gain;
      logic signed [SMP_W-1:0]  fb, b0, b1, b2, a1, a2;
      logic signed [SMP_W-1:0]  pole_y1 [2];
      logic signed [SMP_W-1:0]  bq_x1 [2];
      logic signed [SMP_W-1:0]  bq_x2 [2];
      logic signed [SMP_W-1:0]  bq_y1 [2];
      logic signed [SMP_W-1:0]  bq_y2 [2];
      stereo_type               owed_q [$];
      int                       errors;
      int                       checked;

      function new();
         stage_en = 2'b00;
         errors   = 0;
         checked  = 0;
         clear_pole();
         clear_biquad();
      endfunction

      function void clear_pole();
         gain = POLE_GAIN_UNITY;
         fb   = '0;
         for (int c = 0; c < 2; c++) pole_y1[c] = '0;
      endfunction

      function void clear_biquad();
         b0 = BQ_B0_UNITY;
         b1 = '0;
         b2 = '0;
         a1 = '0;
         a2 = '0;
         for (int c = 0; c < 2; c++) begin
            bq_x1[c] = '0;
            bq_x2[c] = '0;
            bq_y1[c] = '0;
            bq_y2[c] = '0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_ENABLE: begin
               stage_en = val[1:0];
               if (!stage_en[0]) clear_pole();
               if (!stage_en[1]) clear_biquad();
            end
            CSR_POLE_GAIN: gain = val;
            CSR_POLE_FB:   fb   = val[SMP_W-1:0];
            CSR_BQ_B0:     b0   = val[SMP_W-1:0];
            CSR_BQ_B1:     b1   = val[SMP_W-1:0];
            CSR_BQ_B2:     b2   = val[SMP_W-1:0];
            CSR_BQ_A1:     a1   = val[SMP_W-1:0];
            CSR_BQ_A2:     a2   = val[SMP_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [SMP_W-1:0] saturate(longint v);
         if (v < -32768) return SMP_MIN;
         if (v > 32767) return SMP_MAX;
         return SMP_W'(v);
      endfunction

      function stereo_type run_chain(stereo_type s);
         stereo_type              y;
         logic signed [SMP_W-1:0] x;
         logic signed [SMP_W-1:0] v;
         longint                  acc;
         for (int c = 0; c < 2; c++) begin
            x = (c == 0) ? s.left : s.right;
            if (stage_en[0]) begin
               acc = longint'(gain) * x + longint'(fb) * pole_y1[c];
               x = saturate(acc >>> POLE_SHIFT);
               pole_y1[c] = x;
            end
            if (stage_en[1]) begin
               acc = longint'(b0) * x + longint'(b1) * bq_x1[c]
                   + longint'(b2) * bq_x2[c] + longint'(a1) * bq_y1[c]
                   + longint'(a2) * bq_y2[c];
               v = saturate(acc >>> BQ_SHIFT);
               bq_x2[c] = bq_x1[c];
               bq_x1[c] = x;
               bq_y2[c] = bq_y1[c];
               bq_y1[c] = v;
               x = v;
            end
            if (c == 0) y.left = x;
            else y.right = x;
         end
         return y;
      endfunction

      function void note_sample(stereo_type s);
         owed_q.push_back(run_chain(s));
      endfunction

      function void check_result(stereo_type got);
         stereo_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result left %0d right %0d", $time,
                     got.left, got.right);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         if (got.left !== want.left) begin
            $display("%0t: out_left expected %0d actual %0d", $time, want.left, got.left);
            errors++;
         end
         if (got.right !== want.right) begin
            $display("%0t: out_right expected %0d actual %0d", $time, want.right,
                     got.right);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   sobc_req_if req_chan ();
   sobc_rsp_if rsp_chan ();

   filter_scoreboard sb = new();

   int tx_idle_pct;
   int rx_idle_pct;
   int cycles;
   int samples_sent;
   int settings_used;

   stereo_onepole_biquad_chain dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

   // Result sink. It owns rsp ready, stalls at random and once holds off for
   // a long stretch so that the block backs up onto its input.
   initial begin : result_sink
      bit         held;
      stereo_type got;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sb.checked >= HOLD_AT) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.left  = rsp_chan.out_left;
            got.right = rsp_chan.out_right;
            sb.check_result(got);
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [SMP_W-1:0] l,
                              input logic signed [SMP_W-1:0] r);
      stereo_type s;
      int         gap;
      s.left  = l;
      s.right = r;
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.in_left  <= l;
      req_chan.in_right <= r;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sb.note_sample(s);
      samples_sent++;
   endtask

   // Drop valid, wait for every owed result, then give the sequencer time to
   // finish before any register changes.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      settings_used++;
   endtask

   function automatic logic [CSR_W-1:0] pick_coef(bit wide);
      logic [CSR_W-1:0] v;
      case ($urandom_range(7))
         0:       v = wide ? CSR_W'(32768) : CSR_W'(32767);
         1:       v = CSR_W'(-32768);
         2:       v = '0;
         3, 4:    v = CSR_W'($urandom);
         default: v = CSR_W'($urandom_range(0, 8191)) - CSR_W'(4096);
      endcase
      return v;
   endfunction

   function automatic logic [SMP_W-1:0] pick_sample();
      logic [SMP_W-1:0] v;
      case ($urandom_range(15))
         0:       v = SMP_MAX;
         1:       v = SMP_MIN;
         2:       v = '0;
         3:       v = '1;
         default: v = SMP_W'($urandom);
      endcase
      return v;
   endfunction

   // All eight registers in a fresh setting; the enable write lands at a
   // random point, so coefficients may be written while a stage is off.
   task automatic random_setting();
      logic [1:0]       en;
      logic [CSR_W-1:0] val;
      int               en_slot;
      en = 2'($urandom_range(3));
      if ($urandom_range(1)) en = 2'b11;
      val = (CSR_W'($urandom) & ~CSR_W'(3)) | CSR_W'(en);
      en_slot = $urandom_range(1, 8);
      for (int i = 1; i <= 8; i++) begin
         if (i == en_slot) write_csr(CSR_ENABLE, val);
         if (i <= 7) write_csr(csr_index_type'(i), pick_coef(i == 1));
      end
   endtask

   initial begin : stimulus
      int n;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_ENABLE;
      csr_wdata      <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.in_left  <= '0;
      req_chan.in_right <= '0;
      tx_idle_pct   = 11;
      rx_idle_pct   = 49;
      samples_sent  = 0;
      settings_used = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Both stages off: samples pass unchanged.
      write_csr(CSR_ENABLE, CSR_W'(0));
      send_sample(SMP_MIN, SMP_MAX);
      send_sample(SMP_MAX, SMP_MIN);
      send_sample(SMP_W'(0), SMP_W'(-1));
      send_sample(SMP_W'(1), 16'sh5555);
      settle();

      // One-pole with unity gain and the largest feedback: saturates both ways.
      write_csr(CSR_ENABLE, CSR_W'(1));
      write_csr(CSR_POLE_GAIN, CSR_W'(32768));
      write_csr(CSR_POLE_FB, CSR_W'(32767));
      repeat (3) send_sample(SMP_MAX, SMP_MIN);
      repeat (2) send_sample(SMP_MIN, SMP_MAX);
      send_sample(SMP_W'(0), SMP_W'(0));
      settle();

      // Coefficients written while both stages are off, then enabled.
      write_csr(CSR_ENABLE, CSR_W'(0));
      write_csr(CSR_POLE_GAIN, CSR_W'(-32768));
      write_csr(CSR_POLE_FB, CSR_W'(-32768));
      write_csr(CSR_BQ_B0, CSR_W'(32767));
      write_csr(CSR_BQ_B1, CSR_W'(-32768));
      write_csr(CSR_BQ_B2, CSR_W'(32767));
      write_csr(CSR_BQ_A1, CSR_W'(-32768));
      write_csr(CSR_BQ_A2, CSR_W'(32767));
      write_csr(CSR_ENABLE, CSR_W'(3));
      send_sample(SMP_MAX, SMP_MIN);
      send_sample(SMP_MIN, SMP_MAX);
      send_sample(SMP_W'(0), SMP_W'(-1));
      send_sample(SMP_W'(12345), SMP_W'(-12345));
      send_sample(SMP_W'(-1), SMP_W'(1));
      settle();

      // Clearing the biquad bit returns it to passthrough with no history.
      write_csr(CSR_ENABLE, CSR_W'(1));
      send_sample(SMP_W'(1000), SMP_W'(-1000));
      send_sample(SMP_MAX, SMP_MAX);
      send_sample(SMP_MIN, SMP_MIN);
      settle();

      // Clearing the one-pole bit; the biquad keeps its state.
      write_csr(CSR_ENABLE, CSR_W'(2));
      write_csr(CSR_BQ_A1, CSR_W'(8192));
      send_sample(SMP_W'(16384), SMP_W'(-16384));
      send_sample(SMP_W'(0), SMP_W'(0));
      send_sample(SMP_MIN, SMP_MAX);
      settle();

      // Gain patterns beyond the Q15 range are taken as raw 17-bit values.
      write_csr(CSR_ENABLE, CSR_W'(3));
      write_csr(CSR_POLE_GAIN, CSR_W'(65535));
      send_sample(SMP_MAX, SMP_W'(300));
      send_sample(SMP_W'(-2), SMP_MIN);
      settle();
      write_csr(CSR_POLE_GAIN, CSR_W'(-65536));
      send_sample(SMP_MAX, SMP_W'(1));
      send_sample(SMP_MIN, SMP_W'(-7));
      settle();

      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 11;
            rx_idle_pct = 49;
         end else if (n < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 49;
            rx_idle_pct = 11;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         random_setting();
         repeat ($urandom_range(20, 60)) begin
            send_sample(pick_sample(), pick_sample());
            n++;
         end
         settle();
      end

      $display("Sent %0d stereo transactions across %0d register settings;", samples_sent,
               settings_used);
      $display("checked %0d filtered samples, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
